// File: sv/brpc_pkg.sv
package brpc_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int NUM_LINES   = 4;
  localparam int HOLD_W      = 16;

  localparam logic [1:0] MODE_TICK       = 2'd0;
  localparam logic [1:0] MODE_SET_ONE    = 2'd1;
  localparam logic [1:0] MODE_SET_ALL    = 2'd2;
  localparam logic [1:0] MODE_TOGGLE_ALL = 2'd3;

  localparam logic REG_SHORT = 1'b0;
  localparam logic REG_LONG  = 1'b1;

  localparam logic [2:0] LINE_FIRST  = 3'd1;
  localparam logic [2:0] LINE_MASTER = 3'd4;

  localparam logic [NUM_LINES-1:0] ALL_LINES = '1;
  localparam int MASTER_IDX = NUM_LINES - 1;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHORT = 2'd1,
    ACT_LONG  = 2'd2
  } action_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] mode;
    logic [2:0] line_number;
    logic       line_on;
  } cmd_t;

  typedef struct packed {
    logic                 rejected;
    logic                 report_request;
    logic                 status_led_on;
    logic [NUM_LINES-1:0] relay_states;
  } result_t;

endpackage

// File: sv/brpc_lane.sv
module brpc_lane
  import brpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  logic              pressed,
  input  logic [7:0]        short_press_ticks,
  input  logic [HOLD_W-1:0] long_press_ticks,
  output logic              toggle_req
);

  logic              timing;
  logic              timing_next;
  logic [HOLD_W-1:0] hold;
  logic [HOLD_W-1:0] hold_next;
  action_t           action;
  action_t           action_next;
  logic [HOLD_W-1:0] hold_inc;

  always_comb begin
    hold_inc    = (hold == '1) ? hold : hold + 1'b1;
    timing_next = timing;
    hold_next   = hold;
    action_next = action;
    if (pressed) begin
      if (!timing) begin
        // first pressed tick only starts timing
        timing_next = 1'b1;
        hold_next   = '0;
      end else begin
        hold_next = hold_inc;
        if (hold_inc >= long_press_ticks) begin
          action_next = ACT_LONG;
        end else if (hold_inc >= {{(HOLD_W-8){1'b0}}, short_press_ticks}) begin
          action_next = ACT_SHORT;
        end
      end
    end else begin
      timing_next = 1'b0;
      hold_next   = '0;
      action_next = ACT_NONE;
    end
  end

  assign toggle_req = tick && !pressed && (action == ACT_SHORT);

  always_ff @(posedge clk) begin
    if (rst) begin
      timing <= 1'b0;
      hold   <= '0;
      action <= ACT_NONE;
    end else if (tick) begin
      timing <= timing_next;
      hold   <= hold_next;
      action <= action_next;
    end
  end

endmodule

// File: sv/brpc_merge.sv
module brpc_merge
  import brpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [NUM_BUTTONS-1:0] toggles,
  output result_t                result
);

  logic [NUM_LINES-1:0] lines;
  logic [NUM_LINES-1:0] lines_next;
  logic [NUM_LINES-1:0] tog_lines;
  logic [NUM_LINES-1:0] sel;
  logic                 report;
  logic                 rejected;

  always_comb begin
    // button toggles in lane order, turning a line on also turns on the master
    tog_lines = lines;
    for (int n = 0; n < NUM_BUTTONS; n++) begin
      if (toggles[n]) begin
        tog_lines[n] = ~tog_lines[n];
        if (tog_lines[n]) begin
          tog_lines[MASTER_IDX] = 1'b1;
        end
      end
    end

    sel        = '0;
    lines_next = lines;
    report     = 1'b0;
    rejected   = 1'b0;
    case (cmd.mode)
      MODE_TICK: begin
        lines_next = tog_lines;
        report     = |toggles;
      end
      MODE_SET_ONE: begin
        if (cmd.line_number >= LINE_FIRST && cmd.line_number <= LINE_MASTER) begin
          sel = NUM_LINES'(1) << (cmd.line_number[1:0] - 2'd1);
          if (cmd.line_on) begin
            lines_next = lines | sel;
            if (cmd.line_number != LINE_MASTER) begin
              lines_next[MASTER_IDX] = 1'b1;
            end
          end else begin
            lines_next = lines & ~sel;
          end
        end else begin
          rejected = 1'b1;
        end
      end
      MODE_SET_ALL: begin
        lines_next = cmd.line_on ? ALL_LINES : '0;
      end
      MODE_TOGGLE_ALL: begin
        lines_next = (lines != '0) ? '0 : ALL_LINES;
        report     = 1'b1;
      end
      default: begin
        lines_next = lines;
      end
    endcase

    result.relay_states   = lines_next;
    result.status_led_on  = lines_next[MASTER_IDX];
    result.report_request = report;
    result.rejected       = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lines <= ALL_LINES;
    end else if (cmd.valid) begin
      lines <= lines_next;
    end
  end

endmodule

// File: sv/button_press_relay_controller.sv
// Relay controller for four lines (line 4 is the master and drives the status
// LED) with short/long press timing on three active-low buttons. One word is
// taken per clock while s_tready is high; its result word is written into the
// output buffer on acceptance. Each button has its own timing lane, and a merge
// stage applies the lanes' toggles and the line commands to the relay state in
// the same cycle. Results pass through a two-word output buffer, so input keeps
// flowing while one result waits; s_tready drops only when two results wait.
// Thresholds are written over APB: short_press_ticks at 0x0, long_press_ticks
// at 0x4; write them only while the block is idle.
module button_press_relay_controller
  import brpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // mode[1:0], button_levels[4:2], line_number[7:5], line_on[8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // relay_states[3:0], status_led_on[4], report_request[5],
                                 // rejected[6]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]             short_press_ticks;
  logic [HOLD_W-1:0]      long_press_ticks;
  logic                   s_accept;
  logic                   tick;
  cmd_t                   cmd;
  logic [NUM_BUTTONS-1:0] toggles;
  result_t                result;

  result_t                buf_q [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  logic                   m_accept;

  // apb registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_press_ticks <= 8'd50;
      long_press_ticks  <= 16'd2000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SHORT) begin
        short_press_ticks <= pwdata[7:0];
      end else begin
        long_press_ticks <= pwdata[HOLD_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SHORT) begin
      prdata = {24'd0, short_press_ticks};
    end else begin
      prdata = {16'd0, long_press_ticks};
    end
  end

  // input side
  assign s_tready        = (count != 2'd2);
  assign s_accept        = s_tvalid && s_tready;
  assign cmd.valid       = s_accept;
  assign cmd.mode        = s_tdata[1:0];
  assign cmd.line_number = s_tdata[7:5];
  assign cmd.line_on     = s_tdata[8];
  assign tick            = s_accept && (s_tdata[1:0] == MODE_TICK);

  for (genvar n = 0; n < NUM_BUTTONS; n++) begin : g_lane
    brpc_lane u_lane (
      .clk               (clk),
      .rst               (rst),
      .tick              (tick),
      .pressed           (!s_tdata[2+n]),
      .short_press_ticks (short_press_ticks),
      .long_press_ticks  (long_press_ticks),
      .toggle_req        (toggles[n])
    );
  end

  brpc_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .toggles (toggles),
    .result  (result)
  );

  // two-word output buffer
  assign m_tvalid = (count != 2'd0);
  assign m_accept = m_tvalid && m_tready;
  assign m_tdata  = {1'b0, buf_q[rd_ptr]};

  always_ff @(posedge clk) begin
    if (s_accept) begin
      buf_q[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (s_accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (m_accept) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({s_accept, m_accept})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
